@@ src/ge3_pkg.sv @@
// ge3_pkg: shared types, constants and helpers for the 3x3 grayscale erosion block
// no dependencies; used by ge3_ctrl, ge3_min_stage and grayscale_erode_3x3
`timescale 1ns / 1ps

package ge3_pkg;

    // field widths fixed by the stream format
    localparam int PIX_W        = 8;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W   = 16;

    // effective frame size limits and reset values
    localparam int MIN_WIDTH    = 16;
    localparam int MIN_HEIGHT   = 3;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // one item travelling from the accept stage to the min stage
    typedef struct packed {
        logic             is_drain;
        logic             row_ge1;
        logic             row_eq1;
        logic             row_last;
        logic             col_first;
        logic             col_last;
        logic             drain_first;
        logic             drain_last;
        logic [PIX_W-1:0] pixel;
    } ge3_item_t;

    // one result beat waiting on the master side
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last_in_row;
        logic             last_in_frame;
        logic             last_of_run;
    } ge3_result_t;

    function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

@@ src/ge3_ram.sv @@
// ge3_ram: generic simple dual-port RAM, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ge3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/ge3_ctrl.sv @@
// ge3_ctrl: configuration registers, frame position counters and the accept stage
// depends on ge3_pkg; drives the line store read port and the min stage item register
`timescale 1ns / 1ps

module ge3_ctrl #(
    parameter int MAX_WIDTH = 2048,
    parameter int AW        = 11
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input beats
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ge3_pkg::PIX_W-1:0]            s_axis_tdata,
    input  logic [0:0]                           s_axis_tuser,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [0:0]                           cfg_index,
    input  logic [ge3_pkg::CFG_DATA_W-1:0]       cfg_data,
    // line store read port
    output logic                                 rd_en,
    output logic [AW-1:0]                        rd_addr,
    // item handed to the min stage
    output logic                                 s1_valid,
    output ge3_pkg::ge3_item_t                   s1_item,
    output logic [AW-1:0]                        s1_addr,
    input  logic                                 s1_move
);

    // last column index for a programmed width, clamped to the legal range
    function automatic logic [AW-1:0] clamp_last_col(
        input logic [ge3_pkg::CFG_WIDTH_W-1:0] w);
        logic [31:0] wx;
        logic [31:0] lc;
        wx = 32'(w);
        if (wx < 32'(ge3_pkg::MIN_WIDTH))
            lc = 32'(ge3_pkg::MIN_WIDTH) - 32'd1;
        else if (wx > 32'(MAX_WIDTH))
            lc = 32'(MAX_WIDTH) - 32'd1;
        else
            lc = wx - 32'd1;
        return lc[AW-1:0];
    endfunction

    // last row index for a programmed height, at least two
    function automatic logic [ge3_pkg::CFG_HEIGHT_W-1:0] clamp_last_row(
        input logic [ge3_pkg::CFG_HEIGHT_W-1:0] h);
        if (h < ge3_pkg::CFG_HEIGHT_W'(ge3_pkg::MIN_HEIGHT))
            return ge3_pkg::CFG_HEIGHT_W'(ge3_pkg::MIN_HEIGHT - 1);
        else
            return h - ge3_pkg::CFG_HEIGHT_W'(1);
    endfunction

    logic [AW-1:0]                       last_col_reg,  last_col_next;
    logic [ge3_pkg::CFG_HEIGHT_W-1:0]    last_row_reg,  last_row_next;
    logic [AW-1:0]                       col_reg,       col_next;
    logic [ge3_pkg::CFG_HEIGHT_W-1:0]    row_reg,       row_next;
    logic [AW-1:0]                       drain_reg,     drain_next;
    logic                                draining_reg,  draining_next;
    logic                                s1_valid_reg,  s1_valid_next;
    ge3_pkg::ge3_item_t                  s1_item_reg,   s1_item_next;
    logic [AW-1:0]                       s1_addr_reg,   s1_addr_next;

    logic cfg_accept;
    logic in_accept;
    logic is_drain_cmd;
    logic load_stream;
    logic load_drain;
    logic col_last;
    logic row_last;
    logic drain_last;

    assign cfg_ready     = 1'b1;
    assign cfg_accept    = cfg_valid & cfg_ready;
    assign s_axis_tready = ~s1_valid_reg | s1_move;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    // decode the beat against the current position
    assign is_drain_cmd = (s_axis_tuser[0] == ge3_pkg::CMD_DRAIN);
    assign load_stream  = in_accept & ~is_drain_cmd & ~draining_reg;
    assign load_drain   = in_accept &  is_drain_cmd &  draining_reg;
    assign col_last     = (col_reg == last_col_reg);
    assign row_last     = (row_reg == last_row_reg);
    assign drain_last   = (drain_reg == last_col_reg);

    // line store read address: current column, or the column right of the drain window
    always_comb
    begin
        rd_en   = load_stream | load_drain;
        rd_addr = col_reg;
        if (load_drain)
        begin
            rd_addr = drain_last ? drain_reg : drain_reg + AW'(1);
        end
    end

    // next state of configuration, counters and the item register
    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;
        draining_next = draining_reg;
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        s1_addr_next  = s1_addr_reg;

        if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        if (cfg_accept)
        begin
            case (cfg_index[0])
                ge3_pkg::REG_IMAGE_WIDTH:
                begin
                    last_col_next = clamp_last_col(cfg_data[ge3_pkg::CFG_WIDTH_W-1:0]);
                end
                ge3_pkg::REG_IMAGE_HEIGHT:
                begin
                    last_row_next = clamp_last_row(cfg_data);
                end
                default:
                begin
                    last_col_next = last_col_reg;
                end
            endcase
            col_next      = '0;
            row_next      = '0;
            drain_next    = '0;
            draining_next = 1'b0;
        end
        else if (load_stream)
        begin
            s1_valid_next              = 1'b1;
            s1_addr_next               = col_reg;
            s1_item_next.is_drain      = 1'b0;
            s1_item_next.row_ge1       = (row_reg != '0);
            s1_item_next.row_eq1       = (row_reg == ge3_pkg::CFG_HEIGHT_W'(1));
            s1_item_next.row_last      = row_last;
            s1_item_next.col_first     = (col_reg == '0);
            s1_item_next.col_last      = col_last;
            s1_item_next.drain_first   = 1'b0;
            s1_item_next.drain_last    = 1'b0;
            s1_item_next.pixel         = s_axis_tdata;
            if (col_last)
            begin
                col_next = '0;
                if (row_last)
                begin
                    row_next      = '0;
                    draining_next = 1'b1;
                    drain_next    = '0;
                end
                else
                begin
                    row_next = row_reg + ge3_pkg::CFG_HEIGHT_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
        else if (load_drain)
        begin
            s1_valid_next              = 1'b1;
            s1_addr_next               = drain_reg;
            s1_item_next.is_drain      = 1'b1;
            s1_item_next.row_ge1       = 1'b0;
            s1_item_next.row_eq1       = 1'b0;
            s1_item_next.row_last      = 1'b0;
            s1_item_next.col_first     = 1'b0;
            s1_item_next.col_last      = 1'b0;
            s1_item_next.drain_first   = (drain_reg == '0);
            s1_item_next.drain_last    = drain_last;
            s1_item_next.pixel         = s_axis_tdata;
            if (drain_last)
            begin
                drain_next    = '0;
                draining_next = 1'b0;
            end
            else
            begin
                drain_next = drain_reg + AW'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= clamp_last_col(ge3_pkg::CFG_WIDTH_W'(ge3_pkg::RESET_WIDTH));
            last_row_reg <= clamp_last_row(ge3_pkg::CFG_HEIGHT_W'(ge3_pkg::RESET_HEIGHT));
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            drain_reg    <= drain_next;
            draining_reg <= draining_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        s1_addr_reg <= s1_addr_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
    assign s1_addr  = s1_addr_reg;

endmodule

@@ src/ge3_min_stage.sv @@
// ge3_min_stage: column minima, window registers, line store write-back and result buffer
// depends on ge3_pkg; fed by ge3_ctrl and the two ge3_ram line stores
`timescale 1ns / 1ps

module ge3_min_stage #(
    parameter int AW = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // item from the accept stage
    input  logic                        s1_valid,
    input  ge3_pkg::ge3_item_t          s1_item,
    input  logic [AW-1:0]               s1_addr,
    output logic                        s1_move,
    // line store read data and write-back
    input  logic [ge3_pkg::PIX_W-1:0]   older_rd,
    input  logic [ge3_pkg::PIX_W-1:0]   newer_rd,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [ge3_pkg::PIX_W-1:0]   older_wr,
    output logic [ge3_pkg::PIX_W-1:0]   newer_wr,
    // result beats
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [ge3_pkg::PIX_W-1:0]   m_axis_tdata,   // out_pixel
    output logic [1:0]                  m_axis_tuser,   // [0] last_in_row, [1] last_in_frame
    output logic                        m_axis_tlast    // last_of_run
);

    logic [ge3_pkg::PIX_W-1:0] wc0_reg, wc0_next;
    logic [ge3_pkg::PIX_W-1:0] wc1_reg, wc1_next;
    logic [ge3_pkg::PIX_W-1:0] d0_reg,  d0_next;
    ge3_pkg::ge3_result_t      slot0_reg, slot0_next;
    ge3_pkg::ge3_result_t      slot1_reg, slot1_next;
    logic [1:0]                cnt_reg,   cnt_next;

    logic [ge3_pkg::PIX_W-1:0] bp_min;
    logic [ge3_pkg::PIX_W-1:0] v_col;
    logic [ge3_pkg::PIX_W-1:0] ab_min;
    logic [ge3_pkg::PIX_W-1:0] dw0;
    logic [ge3_pkg::PIX_W-1:0] dw1;
    logic [ge3_pkg::PIX_W-1:0] res_mid;
    logic [ge3_pkg::PIX_W-1:0] res_edge;
    logic [ge3_pkg::PIX_W-1:0] res_drain;
    ge3_pkg::ge3_result_t      r0;
    ge3_pkg::ge3_result_t      r1;
    logic [1:0]                n_res;
    logic                      out_space;
    logic                      pop;

    // vertical minima of the current column
    assign bp_min  = ge3_pkg::min8(newer_rd, s1_item.pixel);
    assign v_col   = s1_item.row_eq1 ? bp_min : ge3_pkg::min8(older_rd, bp_min);
    assign ab_min  = ge3_pkg::min8(older_rd, newer_rd);

    // window minima for stream and drain
    assign res_mid   = ge3_pkg::min8(wc0_reg, ge3_pkg::min8(wc1_reg, v_col));
    assign res_edge  = ge3_pkg::min8(wc1_reg, v_col);
    assign dw0       = s1_item.drain_first ? d0_reg : wc0_reg;
    assign dw1       = s1_item.drain_first ? d0_reg : wc1_reg;
    assign res_drain = ge3_pkg::min8(dw0, ge3_pkg::min8(dw1, ab_min));

    // results caused by the item
    always_comb
    begin
        n_res = 2'd0;
        r0    = '{pixel: res_mid, last_in_row: 1'b0, last_in_frame: 1'b0, last_of_run: 1'b1};
        r1    = '{pixel: res_edge, last_in_row: 1'b1, last_in_frame: 1'b0, last_of_run: 1'b1};
        if (s1_item.is_drain)
        begin
            n_res = 2'd1;
            r0    = '{pixel: res_drain, last_in_row: s1_item.drain_last,
                      last_in_frame: s1_item.drain_last, last_of_run: 1'b1};
        end
        else if (s1_item.row_ge1 && !s1_item.col_first)
        begin
            if (s1_item.col_last)
            begin
                n_res          = 2'd2;
                r0.last_of_run = 1'b0;
            end
            else
            begin
                n_res = 2'd1;
            end
        end
    end

    // the item leaves once the buffer can take all its results
    assign out_space = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);
    assign s1_move   = s1_valid && ((n_res == 2'd0) || out_space);
    assign pop       = (cnt_reg != 2'd0) && m_axis_tready;

    // line store write-back: newer row moves to older, new pixel to newer
    assign wr_en    = s1_move & ~s1_item.is_drain;
    assign wr_addr  = s1_addr;
    assign older_wr = newer_rd;
    assign newer_wr = s1_item.pixel;

    // window and drain seed update
    always_comb
    begin
        wc0_next = wc0_reg;
        wc1_next = wc1_reg;
        d0_next  = d0_reg;
        if (s1_move)
        begin
            if (s1_item.is_drain)
            begin
                wc0_next = dw1;
                wc1_next = ab_min;
            end
            else
            begin
                if (s1_item.row_ge1)
                begin
                    wc0_next = s1_item.col_first ? v_col : wc1_reg;
                    wc1_next = v_col;
                end
                if (s1_item.row_last && s1_item.col_first)
                begin
                    d0_next = bp_min;
                end
            end
        end
    end

    // result buffer of two beats
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (s1_move && (n_res != 2'd0))
        begin
            slot0_next = r0;
            slot1_next = r1;
            cnt_next   = n_res;
        end
        else if (pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                slot0_next = slot1_reg;
            end
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wc0_reg   <= wc0_next;
        wc1_reg   <= wc1_next;
        d0_reg    <= d0_next;
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // master side
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = slot0_reg.pixel;
    assign m_axis_tuser  = {slot0_reg.last_in_frame, slot0_reg.last_in_row};
    assign m_axis_tlast  = slot0_reg.last_of_run;

endmodule

@@ src/grayscale_erode_3x3.sv @@
// grayscale_erode_3x3: top level of the 3x3 grayscale erosion (minimum filter)
// depends on ge3_pkg, ge3_ram, ge3_ctrl and ge3_min_stage
`timescale 1ns / 1ps

// Usage
//   s_axis: one beat per pixel of a row-major frame; tuser[0] is the command
//   (pixel or drain), tdata the 8-bit pixel. After the last pixel of a frame,
//   send one drain beat per bottom-row pixel; pixel beats before the drain ends,
//   and drain beats outside a drain, are taken and dropped.
//   m_axis: one beat per output pixel, the minimum of its edge-clamped 3x3
//   window; tuser[0] marks the end of a row, tuser[1] the end of the frame,
//   tlast the last result caused by one input beat.
//   cfg: index 0 writes image_width, index 1 image_height; each write restarts
//   the frame position. Write only while no beat is in flight.
// Pipeline and throughput
//   a beat is registered in the item register and line store read, then its
//   results in the min stage buffer. One input beat per cycle while m_axis takes
//   results; the frame's last pixel gives two results and so holds back the first
//   drain beat. The rate is set by the one-read one-write port per line store.
// Reset and stall
//   reset clears position, counters and the result buffer and loads 640x480;
//   the line stores are not cleared. When m_axis stalls, a two-beat buffer
//   and the min stage fill, then s_axis_tready drops; nothing is lost.

module grayscale_erode_3x3 #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ge3_pkg::PIX_W-1:0]          s_axis_tdata,   // pixel
    input  logic [0:0]                         s_axis_tuser,   // [0] command
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ge3_pkg::PIX_W-1:0]          m_axis_tdata,   // out_pixel
    output logic [1:0]                         m_axis_tuser,   // [0] last_in_row, [1] last_in_frame
    output logic                               m_axis_tlast,   // last_of_run
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [0:0]                         cfg_index,
    input  logic [ge3_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        s1_valid;
    ge3_pkg::ge3_item_t          s1_item;
    logic [AW-1:0]               s1_addr;
    logic                        s1_move;
    logic [ge3_pkg::PIX_W-1:0]   older_rd;
    logic [ge3_pkg::PIX_W-1:0]   newer_rd;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [ge3_pkg::PIX_W-1:0]   older_wr;
    logic [ge3_pkg::PIX_W-1:0]   newer_wr;

    // accept stage and frame position
    ge3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .s1_valid      (s1_valid),
        .s1_item       (s1_item),
        .s1_addr       (s1_addr),
        .s1_move       (s1_move)
    );

    // row r-2 store
    ge3_ram #(
        .WIDTH (ge3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (older_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (older_rd)
    );

    // row r-1 store
    ge3_ram #(
        .WIDTH (ge3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (newer_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (newer_rd)
    );

    // window minima and result buffer
    ge3_min_stage #(
        .AW (AW)
    ) u_min_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1_item       (s1_item),
        .s1_addr       (s1_addr),
        .s1_move       (s1_move),
        .older_rd      (older_rd),
        .newer_rd      (newer_rd),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .older_wr      (older_wr),
        .newer_wr      (newer_wr),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ tb/grayscale_erode_3x3_tb.sv @@
`timescale 1ns / 1ps
// grayscale_erode_3x3_tb: self-checking bench for the 3x3 grayscale erosion block
// streams frames with stray beats, cut-off frames and size changes; checks every result beat
// depends on ge3_pkg and grayscale_erode_3x3

module grayscale_erode_3x3_tb;

    localparam int LINE_MAX      = 2048;
    localparam int CLK_HALF      = 6;
    localparam int ITEM_TARGET   = 1350;
    localparam int TAIL_ITEMS    = 450;
    localparam int WIDE_PIXELS   = 64;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 2000;

    // pixel content styles for generated frames
    localparam int MODE_RANDOM = 0;
    localparam int MODE_SPOTS  = 1;
    localparam int MODE_LEVELS = 2;
    localparam int MODE_RAMP   = 3;
    localparam int MODE_MARKER = 4;

    typedef struct {
        logic                      cmd;
        logic [ge3_pkg::PIX_W-1:0] pix;
    } stim_beat_t;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [ge3_pkg::PIX_W-1:0]      s_axis_tdata  = '0;    // pixel
    logic [0:0]                     s_axis_tuser  = '0;    // [0] command
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [ge3_pkg::PIX_W-1:0]      m_axis_tdata;          // out_pixel
    logic [1:0]                     m_axis_tuser;          // [0] last_in_row, [1] last_in_frame
    logic                           m_axis_tlast;          // last_of_run
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [0:0]                     cfg_index     = '0;
    logic [ge3_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    // stimulus bookkeeping
    stim_beat_t stim_q[$];
    bit         s_taken      = 1'b0;
    bit         idle_en      = 1'b0;
    int         src_gap      = 0;
    int         sink_gap     = 0;
    int         beats_queued = 0;
    int         beats_taken  = 0;
    int         live_items   = 0;
    int         frames_done  = 0;
    int         cfg_writes   = 0;
    int         results_seen = 0;
    int         errors       = 0;
    int         quiet_cycles = 0;

    // erosion predictor state
    logic [ge3_pkg::CFG_WIDTH_W-1:0]  width_reg  =
        ge3_pkg::CFG_WIDTH_W'(ge3_pkg::RESET_WIDTH);
    logic [ge3_pkg::CFG_HEIGHT_W-1:0] height_reg =
        ge3_pkg::CFG_HEIGHT_W'(ge3_pkg::RESET_HEIGHT);
    logic [ge3_pkg::PIX_W-1:0]        row_above2 [LINE_MAX];
    logic [ge3_pkg::PIX_W-1:0]        row_above1 [LINE_MAX];
    logic [ge3_pkg::PIX_W-1:0]        colmin_prev2 = '0;
    logic [ge3_pkg::PIX_W-1:0]        colmin_prev1 = '0;
    int                               cur_col      = 0;
    int                               cur_row      = 0;
    int                               drain_col    = 0;
    bit                               drain_active = 1'b0;
    ge3_pkg::ge3_result_t             expected_min_q[$];

    grayscale_erode_3x3 #(
        .MAX_WIDTH(LINE_MAX)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic logic [ge3_pkg::PIX_W-1:0] lesser(input logic [ge3_pkg::PIX_W-1:0] x,
                                                         input logic [ge3_pkg::PIX_W-1:0] y);
        return (x < y) ? x : y;
    endfunction

    // effective frame size after saturation
    function automatic int frame_width();
        int w;
        w = width_reg;
        if (w < ge3_pkg::MIN_WIDTH) w = ge3_pkg::MIN_WIDTH;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int frame_height();
        int h;
        h = height_reg;
        if (h < ge3_pkg::MIN_HEIGHT) h = ge3_pkg::MIN_HEIGHT;
        return h;
    endfunction

    function automatic ge3_pkg::ge3_result_t pack_result(input logic [ge3_pkg::PIX_W-1:0] pix,
                                                         input logic row_end,
                                                         input logic frame_end);
        ge3_pkg::ge3_result_t r;
        r.pixel         = pix;
        r.last_in_row   = row_end;
        r.last_in_frame = frame_end;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // any register write sends the frame position back to the top-left pixel
    task automatic restart_frame();
        cur_col      = 0;
        cur_row      = 0;
        drain_col    = 0;
        drain_active = 1'b0;
        colmin_prev2 = '0;
        colmin_prev1 = '0;
    endtask

    // expected min results caused by one accepted input beat
    task automatic predict_erosion(input logic cmd, input logic [ge3_pkg::PIX_W-1:0] pix);
        int                        w, h, k, lo, hi, j, n;
        logic [ge3_pkg::PIX_W-1:0] m, a, b, v;
        ge3_pkg::ge3_result_t      res [2];
        w = frame_width();
        h = frame_height();
        n = 0;
        if (cmd == ge3_pkg::CMD_DRAIN)
        begin
            // bottom row: window clamps to rows h-2 and h-1 held in the line stores
            if (drain_active)
            begin
                k  = (drain_col >= w) ? w - 1 : drain_col;
                lo = (k == 0) ? 0 : k - 1;
                hi = (k + 1 >= w) ? w - 1 : k + 1;
                m  = '1;
                for (j = lo; j <= hi; j++)
                    m = lesser(m, lesser(row_above2[j], row_above1[j]));
                res[0] = pack_result(m, k == w - 1, k == w - 1);
                n = 1;
                if (k == w - 1)
                begin
                    drain_active = 1'b0;
                    drain_col    = 0;
                end
                else
                begin
                    drain_col = k + 1;
                end
            end
        end
        else if (!drain_active)
        begin
            if (cur_col >= w) cur_col = 0;
            if (cur_row >= h) cur_row = 0;
            a = row_above2[cur_col];
            b = row_above1[cur_col];
            row_above2[cur_col] = b;
            row_above1[cur_col] = pix;
            // row r completes the windows of row r-1; row 1 clamps the top edge
            if (cur_row >= 1)
            begin
                v = (cur_row == 1) ? lesser(b, pix) : lesser(a, lesser(b, pix));
                if (cur_col == 0)
                begin
                    colmin_prev2 = v;
                    colmin_prev1 = v;
                end
                else
                begin
                    res[n] = pack_result(lesser(colmin_prev2, lesser(colmin_prev1, v)),
                                         1'b0, 1'b0);
                    n++;
                    colmin_prev2 = colmin_prev1;
                    colmin_prev1 = v;
                end
                if (cur_col == w - 1)
                begin
                    res[n] = pack_result(lesser(colmin_prev2, v), 1'b1, 1'b0);
                    n++;
                end
            end
            // advance position; the last pixel of the frame starts the drain
            if (cur_col == w - 1)
            begin
                cur_col = 0;
                if (cur_row == h - 1)
                begin
                    cur_row      = 0;
                    drain_active = 1'b1;
                    drain_col    = 0;
                end
                else
                begin
                    cur_row++;
                end
            end
            else
            begin
                cur_col++;
            end
        end
        for (j = 0; j < n; j++)
        begin
            if (j == n - 1) res[j].last_of_run = 1'b1;
            expected_min_q.push_back(res[j]);
        end
    endtask

    // input beat sender
    always @(negedge clk)
    begin : feeder
        stim_beat_t nxt;
        if (rst_n && (!s_axis_tvalid || s_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (stim_q.size() > 0)
            begin
                nxt = stim_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.pix;
                s_axis_tuser  <= nxt.cmd;
                if (idle_en && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 7);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin : sink_stall
        if (rst_n)
        begin
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (idle_en && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 7);
            end
        end
    end

    // accepted input beats feed the predictor, result beats are checked, watchdog
    always @(posedge clk)
    begin : result_check
        ge3_pkg::ge3_result_t want;
        if (rst_n)
        begin
            s_taken = s_axis_tvalid && s_axis_tready;
            if (s_taken)
            begin
                predict_erosion(s_axis_tuser[0], s_axis_tdata);
                beats_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_min_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, got pixel %0d", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_min_q.pop_front();
                    if (m_axis_tdata !== want.pixel)
                    begin
                        $display("%0t: out_pixel mismatch, expected %0d, got %0d",
                                 $time, want.pixel, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser[0] !== want.last_in_row)
                    begin
                        $display("%0t: last_in_row mismatch, expected %0b, got %0b",
                                 $time, want.last_in_row, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tuser[1] !== want.last_in_frame)
                    begin
                        $display("%0t: last_in_frame mismatch, expected %0b, got %0b",
                                 $time, want.last_in_frame, m_axis_tuser[1]);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last_of_run)
                    begin
                        $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                                 $time, want.last_of_run, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (s_taken || (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: watchdog, no beat for %0d cycles, %0d results pending",
                             $time, quiet_cycles, expected_min_q.size());
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic push_beat(input logic cmd, input logic [ge3_pkg::PIX_W-1:0] pix);
        stim_beat_t b;
        b.cmd = cmd;
        b.pix = pix;
        stim_q.push_back(b);
        beats_queued++;
    endtask

    function automatic logic [ge3_pkg::PIX_W-1:0] pick_pixel(input int mode, input int r,
                                                              input int c, input int w,
                                                              input int h);
        case (mode)
            MODE_RANDOM:
                return ge3_pkg::PIX_W'($urandom_range(0, 255));
            MODE_SPOTS:
                return ($urandom_range(0, 9) == 0) ? ge3_pkg::PIX_W'($urandom_range(0, 254))
                                                   : 8'hFF;
            MODE_LEVELS:
                case ($urandom_range(0, 5))
                    0:       return 8'h00;
                    1:       return 8'hFF;
                    2:       return 8'h01;
                    3:       return 8'hFE;
                    4:       return 8'h80;
                    default: return 8'h7F;
                endcase
            MODE_RAMP:
                return ge3_pkg::PIX_W'(r * 7 + c * 3 + $urandom_range(0, 4));
            default:
            begin
                // bright field, distinct dark corners and a black centre: shows edge clamping
                if (r == 0 && c == 0) return 8'h10;
                if (r == 0 && c == w - 1) return 8'h20;
                if (r == h - 1 && c == 0) return 8'h30;
                if (r == h - 1 && c == w - 1) return 8'h40;
                if (r == h / 2 && c == w / 2) return 8'h00;
                return ge3_pkg::PIX_W'(8'hF0 + (c & 15));
            end
        endcase
    endfunction

    // rows [row_from, row_to) of the current frame, then some drain beats
    task automatic queue_part(input int row_from, input int row_to, input int drains,
                              input int mode, input bit noisy);
        int w, h, r, c, k;
        w = frame_width();
        h = frame_height();
        for (r = row_from; r < row_to; r++)
        begin
            for (c = 0; c < w; c++)
            begin
                // stray drain while pixels stream: dropped
                if (noisy && $urandom_range(0, 39) == 0)
                    push_beat(ge3_pkg::CMD_DRAIN, ge3_pkg::PIX_W'($urandom_range(0, 255)));
                push_beat(ge3_pkg::CMD_PIXEL, pick_pixel(mode, r, c, w, h));
                live_items++;
            end
        end
        for (k = 0; k < drains; k++)
        begin
            // stray pixel during the drain: dropped
            if (noisy && $urandom_range(0, 19) == 0)
                push_beat(ge3_pkg::CMD_PIXEL, ge3_pkg::PIX_W'($urandom_range(0, 255)));
            push_beat(ge3_pkg::CMD_DRAIN, ge3_pkg::PIX_W'($urandom_range(0, 255)));
            live_items++;
        end
        // drains past the end of the bottom row: dropped
        if (noisy && drains == w && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2))
                push_beat(ge3_pkg::CMD_DRAIN, ge3_pkg::PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic queue_frame(input int mode, input bit noisy);
        queue_part(0, frame_height(), frame_width(), mode, noisy);
        frames_done++;
    endtask

    // wait until every queued beat is taken and every result has come out
    task automatic settle_all();
        do
            @(negedge clk);
        while (beats_taken != beats_queued || expected_min_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [ge3_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == ge3_pkg::REG_IMAGE_WIDTH)
            width_reg = val[ge3_pkg::CFG_WIDTH_W-1:0];
        else
            height_reg = val[ge3_pkg::CFG_HEIGHT_W-1:0];
        restart_frame();
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                             kind, mode, split, h, c;
        bit                             need_cfg;
        logic [ge3_pkg::CFG_DATA_W-1:0] wval, hval;
        foreach (row_above2[i])
        begin
            row_above2[i] = '0;
            row_above1[i] = '0;
        end
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset size 640x480: stray drains and extreme pixels on the top row, no results
        idle_en = 1'b1;
        push_beat(ge3_pkg::CMD_DRAIN, 8'hFF);
        push_beat(ge3_pkg::CMD_DRAIN, 8'h00);
        push_beat(ge3_pkg::CMD_PIXEL, 8'h00);
        push_beat(ge3_pkg::CMD_PIXEL, 8'hFF);
        push_beat(ge3_pkg::CMD_PIXEL, 8'hAA);
        push_beat(ge3_pkg::CMD_PIXEL, 8'h55);
        push_beat(ge3_pkg::CMD_DRAIN, 8'h5A);
        settle_all();

        // sizes below range saturate to 16x3; marker frame with explicit stray beats
        write_reg(ge3_pkg::REG_IMAGE_WIDTH, 16'h0000);
        write_reg(ge3_pkg::REG_IMAGE_HEIGHT, 16'h0000);
        queue_part(0, frame_height(), 0, MODE_MARKER, 1'b0);
        push_beat(ge3_pkg::CMD_PIXEL, 8'h00);
        queue_part(frame_height(), frame_height(), frame_width(), MODE_MARKER, 1'b0);
        push_beat(ge3_pkg::CMD_DRAIN, 8'hFF);
        frames_done++;
        // next frame straight after the drain, no register write
        queue_frame(MODE_LEVELS, 1'b1);
        settle_all();

        // random sizes, content and frame shapes
        need_cfg = 1'b1;
        while (live_items < ITEM_TARGET - TAIL_ITEMS)
        begin
            idle_en = ($urandom_range(0, 3) != 0);
            if (need_cfg || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 4))
                    0:       wval = 16'hF010;
                    1:       wval = 16'($urandom_range(0, 15));
                    2:       wval = 16'd17;
                    default: wval = 16'($urandom_range(16, 48)) | 16'($urandom_range(0, 15) << 12);
                endcase
                hval = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2))
                                                   : 16'($urandom_range(3, 6));
                case ($urandom_range(0, 3))
                    0:       write_reg(ge3_pkg::REG_IMAGE_WIDTH, wval);
                    1:       write_reg(ge3_pkg::REG_IMAGE_HEIGHT, hval);
                    2:
                    begin
                        write_reg(ge3_pkg::REG_IMAGE_HEIGHT, hval);
                        write_reg(ge3_pkg::REG_IMAGE_WIDTH, wval);
                    end
                    default:
                    begin
                        write_reg(ge3_pkg::REG_IMAGE_WIDTH, wval);
                        write_reg(ge3_pkg::REG_IMAGE_HEIGHT, hval);
                    end
                endcase
                need_cfg = 1'b0;
            end
            kind = $urandom_range(0, 9);
            mode = $urandom_range(MODE_RANDOM, MODE_RAMP);
            h    = frame_height();
            if (kind == 0)
            begin
                // frame cut off mid-stream, restarted by the next write
                queue_part(0, $urandom_range(1, h - 1), 0, mode, 1'b1);
                need_cfg = 1'b1;
            end
            else if (kind == 1)
            begin
                // drain cut short
                queue_part(0, h, $urandom_range(1, frame_width() - 1), mode, 1'b1);
                need_cfg = 1'b1;
            end
            else if (kind == 2)
            begin
                // sender holds mid-frame until every result is out
                split = $urandom_range(1, h - 1);
                queue_part(0, split, 0, mode, 1'b1);
                settle_all();
                queue_part(split, h, frame_width(), mode, 1'b1);
                frames_done++;
            end
            else
            begin
                queue_frame(mode, 1'b1);
            end
            settle_all();
        end

        // tallest frame: a few rows, then a restart
        write_reg(ge3_pkg::REG_IMAGE_WIDTH, 16'd20);
        write_reg(ge3_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
        queue_part(0, 4, 0, MODE_RANDOM, 1'b1);
        settle_all();

        // all-ones width saturates to the line store size; start of the top row only
        write_reg(ge3_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(ge3_pkg::REG_IMAGE_HEIGHT, 16'd2);
        for (c = 0; c < WIDE_PIXELS; c++)
        begin
            push_beat(ge3_pkg::CMD_PIXEL,
                      pick_pixel(MODE_SPOTS, 0, c, frame_width(), frame_height()));
            live_items++;
        end
        settle_all();

        // closing frames back to back at full rate
        idle_en = 1'b0;
        write_reg(ge3_pkg::REG_IMAGE_WIDTH, 16'd24);
        write_reg(ge3_pkg::REG_IMAGE_HEIGHT, 16'd4);
        queue_frame(MODE_RANDOM, 1'b0);
        queue_frame(MODE_RAMP, 1'b0);
        settle_all();

        $display("run: %0d frames, %0d register writes, %0d input beats, %0d results checked",
                 frames_done, cfg_writes, beats_taken, results_seen);
        $display("run: widths 16 to 48 and saturated, heights 3 to 65535, stray, cut-off and held beats");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/ge3_pkg.sv
src/ge3_ram.sv
src/ge3_ctrl.sv
src/ge3_min_stage.sv
src/grayscale_erode_3x3.sv
tb/grayscale_erode_3x3_tb.sv
